// ===== sv/ddr_pkg.sv =====
`timescale 1ns / 1ps

package ddr_pkg;

    // field and register widths
    localparam int CHAN_W     = 10;
    localparam int TIME_W     = 10;
    localparam int SAMP_W     = 16;
    localparam int FREQ_W     = 20;
    localparam int SCALE_W    = 40;
    localparam int SHIFT_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // frequency range and shift limit
    localparam logic [FREQ_W-1:0]  FREQ_MAX        = 20'hFFFFF;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT_LIMIT = 13'd4096;

    // reciprocal of f^2: floor(2^56 / F^2), 57 quotient bits
    localparam int SQ_W       = 2 * FREQ_W;
    localparam int Q_W        = 57;
    localparam int DIV_STAGES = Q_W;

    // delay product: mag * scale, split into halves
    localparam int MAG_LO_W = 29;
    localparam int MAG_HI_W = Q_W - MAG_LO_W;
    localparam int SC_LO_W  = 20;
    localparam int SC_HI_W  = SCALE_W - SC_LO_W;
    localparam int PROD_W   = Q_W + SCALE_W;
    localparam int DLY_W    = PROD_W - 48;

    // reset values
    localparam logic [FREQ_W-1:0]  START_FREQ_RST   = 20'd204800;
    localparam logic [FREQ_W-1:0]  CHANNEL_STEP_RST = 20'hFFF9C;
    localparam logic [SCALE_W-1:0] DELAY_SCALE_RST  = '0;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT_RST    = '0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_FREQ   = 2'd0,
        REG_CHANNEL_STEP = 2'd1,
        REG_DELAY_SCALE  = 2'd2,
        REG_MAX_SHIFT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  start_freq;
        logic [FREQ_W-1:0]  channel_step;
        logic [SCALE_W-1:0] delay_scale;
        logic [SHIFT_W-1:0] max_shift;
    } cfg_t;

    // fields that ride along the pipeline
    typedef struct packed {
        logic [CHAN_W-1:0]        chan;
        logic [TIME_W-1:0]        tbin;
        logic signed [SAMP_W-1:0] samp;
    } meta_t;

    typedef struct packed {
        logic            qb;
        logic [SQ_W-1:0] rem;
    } div_step_t;

    // one restoring division step
    function automatic div_step_t div_step(input logic [SQ_W-1:0] rem,
                                           input logic [SQ_W-1:0] d,
                                           input logic nbit);
        logic [SQ_W:0] sh;
        logic [SQ_W:0] diff;
        div_step_t     res;
        sh   = {rem, nbit};
        diff = sh - {1'b0, d};
        if (sh >= {1'b0, d})
        begin
            res.qb  = 1'b1;
            res.rem = diff[SQ_W-1:0];
        end
        else
        begin
            res.qb  = 1'b0;
            res.rem = sh[SQ_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ddr_front.sv =====
`timescale 1ns / 1ps

module ddr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ddr_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  ddr_pkg::meta_t  in_meta,
    output logic            out_valid,
    output logic [ddr_pkg::SQ_W-1:0] sq_ch,
    output logic [ddr_pkg::SQ_W-1:0] sq_ref,
    output ddr_pkg::meta_t  out_meta
);
    import ddr_pkg::*;

    logic                     v1_reg, v2_reg, v3_reg;
    meta_t                    m1_reg, m2_reg, m3_reg;
    logic signed [30:0]       prod_reg;
    logic signed [30:0]       prod_next;
    logic signed [31:0]       fsum;
    logic [FREQ_W-1:0]        fcode_next, fref_next;
    logic [FREQ_W-1:0]        fcode_reg, fref_reg;
    logic [SQ_W-1:0]          sqc_reg, sqr_reg;

    // channel offset
    assign prod_next = $signed({1'b0, in_meta.chan}) * $signed(cfg.channel_step);

    // channel frequency, clamped to the code range
    always_comb
    begin
        fsum = $signed({12'b0, cfg.start_freq}) + 32'(prod_reg);
        if (fsum < 32'sd1)
            fcode_next = 20'd1;
        else if (fsum > $signed({12'b0, FREQ_MAX}))
            fcode_next = FREQ_MAX;
        else
            fcode_next = fsum[FREQ_W-1:0];
        fref_next = (cfg.start_freq == '0) ? 20'd1 : cfg.start_freq;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= in_meta;
            prod_reg  <= prod_next;
            m2_reg    <= m1_reg;
            fcode_reg <= fcode_next;
            fref_reg  <= fref_next;
            m3_reg    <= m2_reg;
            sqc_reg   <= fcode_reg * fcode_reg;
            sqr_reg   <= fref_reg * fref_reg;
        end
    end

    assign out_valid = v3_reg;
    assign sq_ch     = sqc_reg;
    assign sq_ref    = sqr_reg;
    assign out_meta  = m3_reg;

endmodule

// ===== sv/ddr_recip.sv =====
`timescale 1ns / 1ps

module ddr_recip (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [ddr_pkg::SQ_W-1:0] sq_ch,
    input  logic [ddr_pkg::SQ_W-1:0] sq_ref,
    input  ddr_pkg::meta_t  in_meta,
    output logic            out_valid,
    output logic [ddr_pkg::Q_W-1:0] r_ch,
    output logic [ddr_pkg::Q_W-1:0] r_ref,
    output ddr_pkg::meta_t  out_meta
);
    import ddr_pkg::*;

    logic            valid_reg [DIV_STAGES];
    logic [SQ_W-1:0] rc_reg    [DIV_STAGES];
    logic [SQ_W-1:0] rr_reg    [DIV_STAGES];
    logic [SQ_W-1:0] dc_reg    [DIV_STAGES];
    logic [SQ_W-1:0] dr_reg    [DIV_STAGES];
    logic [Q_W-1:0]  qc_reg    [DIV_STAGES];
    logic [Q_W-1:0]  qr_reg    [DIV_STAGES];
    meta_t           m_reg     [DIV_STAGES];

    // one quotient bit per stage, both lanes side by side
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic            v_prev;
        logic [SQ_W-1:0] rc_prev, rr_prev, dc_prev, dr_prev;
        logic [Q_W-1:0]  qc_prev, qr_prev;
        meta_t           m_prev;
        div_step_t       sc, sr;

        if (k == 0)
        begin : g_first
            assign v_prev  = in_valid;
            assign rc_prev = '0;
            assign rr_prev = '0;
            assign dc_prev = sq_ch;
            assign dr_prev = sq_ref;
            assign qc_prev = '0;
            assign qr_prev = '0;
            assign m_prev  = in_meta;
        end
        else
        begin : g_next
            assign v_prev  = valid_reg[k-1];
            assign rc_prev = rc_reg[k-1];
            assign rr_prev = rr_reg[k-1];
            assign dc_prev = dc_reg[k-1];
            assign dr_prev = dr_reg[k-1];
            assign qc_prev = qc_reg[k-1];
            assign qr_prev = qr_reg[k-1];
            assign m_prev  = m_reg[k-1];
        end

        // the dividend's only set bit enters at the first stage
        assign sc = div_step(rc_prev, dc_prev, 1'(k == 0));
        assign sr = div_step(rr_prev, dr_prev, 1'(k == 0));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rc_reg[k] <= sc.rem;
                rr_reg[k] <= sr.rem;
                dc_reg[k] <= dc_prev;
                dr_reg[k] <= dr_prev;
                qc_reg[k] <= qc_prev | (Q_W'(sc.qb) << (Q_W - 1 - k));
                qr_reg[k] <= qr_prev | (Q_W'(sr.qb) << (Q_W - 1 - k));
                m_reg[k]  <= m_prev;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign r_ch      = qc_reg[DIV_STAGES-1];
    assign r_ref     = qr_reg[DIV_STAGES-1];
    assign out_meta  = m_reg[DIV_STAGES-1];

endmodule

// ===== sv/ddr_delay.sv =====
`timescale 1ns / 1ps

module ddr_delay (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ddr_pkg::cfg_t   cfg,
    input  logic            in_valid,
    input  logic [ddr_pkg::Q_W-1:0] r_ch,
    input  logic [ddr_pkg::Q_W-1:0] r_ref,
    input  ddr_pkg::meta_t  in_meta,
    output logic            out_valid,
    output logic [ddr_pkg::CHAN_W-1:0]  chan_out,
    output logic [ddr_pkg::SHIFT_W-1:0] shifted_time,
    output logic signed [ddr_pkg::SAMP_W-1:0] sample_out,
    output logic            delay_clamped
);
    import ddr_pkg::*;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    meta_t               m1_reg, m2_reg, m3_reg;
    logic                neg1_reg, neg2_reg, neg3_reg;
    logic [Q_W-1:0]      mag_reg;
    logic [MAG_LO_W+SC_LO_W-1:0] p0_reg;
    logic [MAG_LO_W+SC_HI_W-1:0] p1_reg;
    logic [MAG_HI_W+SC_LO_W-1:0] p2_reg;
    logic [MAG_HI_W+SC_HI_W-1:0] p3_reg;
    logic [PROD_W-1:0]   prod;
    logic [DLY_W-1:0]    q_reg;
    logic [SHIFT_W-1:0]  maxs;
    logic [SHIFT_W-1:0]  delay;
    logic                flag_next;
    logic [SHIFT_W-1:0]  shifted_next;
    logic [CHAN_W-1:0]   chan_reg;
    logic [SHIFT_W-1:0]  shifted_reg;
    logic signed [SAMP_W-1:0] samp_reg;
    logic                flag_reg;

    // sum of the partial products; the delay is taken from bit 48 up
    assign prod = PROD_W'(p0_reg)
                + (PROD_W'(p1_reg) << SC_LO_W)
                + (PROD_W'(p2_reg) << MAG_LO_W)
                + (PROD_W'(p3_reg) << (MAG_LO_W + SC_LO_W));

    // clamp the delay and place the column
    always_comb
    begin
        maxs = (cfg.max_shift > MAX_SHIFT_LIMIT) ? MAX_SHIFT_LIMIT : cfg.max_shift;
        priority if (neg3_reg)
        begin
            delay     = '0;
            flag_next = (q_reg != '0);
        end
        else if (q_reg > DLY_W'(maxs))
        begin
            delay     = maxs;
            flag_next = 1'b1;
        end
        else
        begin
            delay     = q_reg[SHIFT_W-1:0];
            flag_next = 1'b0;
        end
        shifted_next = SHIFT_W'(m3_reg.tbin) + maxs - delay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // difference of reciprocals
            neg1_reg <= (r_ch < r_ref);
            mag_reg  <= (r_ch < r_ref) ? (r_ref - r_ch) : (r_ch - r_ref);
            m1_reg   <= in_meta;
            // partial products
            p0_reg   <= mag_reg[MAG_LO_W-1:0] * cfg.delay_scale[SC_LO_W-1:0];
            p1_reg   <= mag_reg[MAG_LO_W-1:0] * cfg.delay_scale[SCALE_W-1:SC_LO_W];
            p2_reg   <= mag_reg[Q_W-1:MAG_LO_W] * cfg.delay_scale[SC_LO_W-1:0];
            p3_reg   <= mag_reg[Q_W-1:MAG_LO_W] * cfg.delay_scale[SCALE_W-1:SC_LO_W];
            neg2_reg <= neg1_reg;
            m2_reg   <= m1_reg;
            // truncated delay
            q_reg    <= prod[PROD_W-1:48];
            neg3_reg <= neg2_reg;
            m3_reg   <= m2_reg;
            // output register
            chan_reg    <= m3_reg.chan;
            shifted_reg <= shifted_next;
            samp_reg    <= m3_reg.samp;
            flag_reg    <= flag_next;
        end
    end

    assign out_valid     = v4_reg;
    assign chan_out      = chan_reg;
    assign shifted_time  = shifted_reg;
    assign sample_out    = samp_reg;
    assign delay_clamped = flag_reg;

endmodule

// ===== sv/dispersion_delay_remap_unit.sv =====
`timescale 1ns / 1ps

// Dedispersion remapper: each sample (channel, time bin, intensity) is sent on
// to column time + max_shift - delay, where delay = scale * (2^56/f^2 -
// 2^56/f0^2) / 2^48 in samples, truncated toward zero and clamped to
// 0..max_shift (tuser flags a clamp). One item is accepted per cycle while the
// skid entry is free. An item passes the stages for channel frequency and
// squares, the pipelined reciprocal divider (one quotient bit per stage, channel
// and reference lanes side by side), then the delay product, clamp and output.
// A one-entry skid stage keeps tready registered; a stall holds every stage.
// Registers must be written only while no item is in flight (not enforced).

module dispersion_delay_remap_unit (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [ddr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // chan_index [9:0], time_index [19:10], sample_in [35:20], zero pad
    input  logic [ddr_pkg::IN_DATA_W-1:0]  s_tdata,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // chan_out [9:0], shifted_time [22:10], sample_out [38:23], zero pad
    output logic [ddr_pkg::OUT_DATA_W-1:0] m_tdata,
    // delay_clamped [0]
    output logic        m_tuser
);
    import ddr_pkg::*;

    cfg_t            cfg_reg;
    logic            en;
    logic            skid_valid_reg, skid_valid_next;
    meta_t           skid_meta_reg;
    meta_t           in_meta;
    logic            fr_valid;
    meta_t           fr_meta;
    logic            f_valid, r_valid;
    logic [SQ_W-1:0] sq_ch, sq_ref;
    meta_t           f_meta, r_meta;
    logic [Q_W-1:0]  r_ch, r_ref;
    logic [CHAN_W-1:0]   chan_out;
    logic [SHIFT_W-1:0]  shifted_time;
    logic signed [SAMP_W-1:0] sample_out;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_freq   <= START_FREQ_RST;
            cfg_reg.channel_step <= CHANNEL_STEP_RST;
            cfg_reg.delay_scale  <= DELAY_SCALE_RST;
            cfg_reg.max_shift    <= MAX_SHIFT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_FREQ:   cfg_reg.start_freq   <= cfg_data[FREQ_W-1:0];
                REG_CHANNEL_STEP: cfg_reg.channel_step <= cfg_data[FREQ_W-1:0];
                REG_DELAY_SCALE:  cfg_reg.delay_scale  <= cfg_data[SCALE_W-1:0];
                REG_MAX_SHIFT:    cfg_reg.max_shift    <= cfg_data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless the output item is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;

    assign in_meta.chan = s_tdata[9:0];
    assign in_meta.tbin = s_tdata[19:10];
    assign in_meta.samp = s_tdata[35:20];

    // skid entry feeds the pipeline first
    assign fr_valid = skid_valid_reg || s_tvalid;
    assign fr_meta  = skid_valid_reg ? skid_meta_reg : in_meta;

    always_comb
    begin
        if (en)
            skid_valid_next = 1'b0;
        else
            skid_valid_next = skid_valid_reg || s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!en && !skid_valid_reg)
            skid_meta_reg <= in_meta;
    end

    ddr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (fr_valid),
        .in_meta   (fr_meta),
        .out_valid (f_valid),
        .sq_ch     (sq_ch),
        .sq_ref    (sq_ref),
        .out_meta  (f_meta)
    );

    ddr_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .sq_ch     (sq_ch),
        .sq_ref    (sq_ref),
        .in_meta   (f_meta),
        .out_valid (r_valid),
        .r_ch      (r_ch),
        .r_ref     (r_ref),
        .out_meta  (r_meta)
    );

    ddr_delay u_delay (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cfg           (cfg_reg),
        .in_valid      (r_valid),
        .r_ch          (r_ch),
        .r_ref         (r_ref),
        .in_meta       (r_meta),
        .out_valid     (m_tvalid),
        .chan_out      (chan_out),
        .shifted_time  (shifted_time),
        .sample_out    (sample_out),
        .delay_clamped (m_tuser)
    );

    assign m_tdata = {1'b0, sample_out, shifted_time, chan_out};

    // the skid entry drains on the first advancing cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        en && skid_valid_reg |=> !skid_valid_reg)
        else $error("skid entry not drained");

    // input back-pressure only follows an output stall
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output stall");

    // a held skid entry stays put while the pipeline is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !en |=> skid_valid_reg && $stable(skid_meta_reg))
        else $error("held skid entry changed");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ddr_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0]  chan;
        logic [12:0]        col;
        logic [SAMP_W-1:0]  samp;
        logic               clamped;
    } remap_t;

    localparam int LATENCY = 64;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;

    // model copy of the registers
    logic [FREQ_W-1:0]  f0_reg;
    logic [FREQ_W-1:0]  step_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SHIFT_W-1:0] shift_reg;

    remap_t expected_q[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;

    dispersion_delay_remap_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #4 clk = ~clk;

    // floor(2^56 / F^2) with the frequency code clamped to 1..max
    function automatic logic [63:0] inv_freq_sq(input longint f);
        logic [63:0] fc;
        if (f < 1)
            fc = 1;
        else if (f > 64'hFFFFF)
            fc = 64'hFFFFF;
        else
            fc = f;
        return (64'd1 << 56) / (fc * fc);
    endfunction

    function automatic remap_t remap_sample(input logic [9:0] chan, input logic [9:0] tbin,
                                            input logic [15:0] samp);
        longint fchan;
        logic [63:0] r_ch, r_ref, mag;
        logic [127:0] prod;
        logic [63:0] q, maxs, dly;
        bit neg;
        remap_t r;
        fchan = longint'(f0_reg) + longint'(chan) * longint'($signed(step_reg));
        r_ch = inv_freq_sq(fchan);
        r_ref = inv_freq_sq(longint'(f0_reg));
        neg = r_ch < r_ref;
        mag = neg ? r_ref - r_ch : r_ch - r_ref;
        prod = 128'(mag) * 128'(scale_reg);
        q = 64'(prod >> 48);
        maxs = (shift_reg > MAX_SHIFT_LIMIT) ? 64'(MAX_SHIFT_LIMIT) : 64'(shift_reg);
        r.clamped = 1'b0;
        if (neg)
        begin
            dly = 0;
            r.clamped = (q != 0);
        end
        else if (q > maxs)
        begin
            dly = maxs;
            r.clamped = 1'b1;
        end
        else
            dly = q;
        r.chan = chan;
        r.col = 13'(64'(tbin) + maxs - dly);
        r.samp = samp;
        return r;
    endfunction

    // register write, only while idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_START_FREQ:   f0_reg = val[FREQ_W-1:0];
            REG_CHANNEL_STEP: step_reg = val[FREQ_W-1:0];
            REG_DELAY_SCALE:  scale_reg = val[SCALE_W-1:0];
            default:          shift_reg = val[SHIFT_W-1:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // tvalid stays high between back-to-back items and drops only before a gap
    task automatic send_sample(input logic [9:0] chan, input logic [9:0] tbin,
                               input logic [15:0] samp, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, samp, tbin, chan};
        expected_q.push_back(remap_sample(chan, tbin, samp));
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // set of registers chosen at random, deep and shallow delays alike
    task automatic random_setting;
        write_reg(REG_START_FREQ, $urandom_range(0, 3) == 0 ? $urandom_range(0, 20'hFFFFF)
                                                            : $urandom_range(20000, 400000));
        write_reg(REG_CHANNEL_STEP, $urandom_range(0, 3) == 0 ? $urandom_range(0, 20'hFFFFF)
                                                              : 20'(-$urandom_range(0, 300)));
        write_reg(REG_DELAY_SCALE, $urandom_range(0, 2) == 0
                  ? {8'($urandom_range(0, 255)), $urandom()}
                  : 40'($urandom_range(0, 2000000)));
        write_reg(REG_MAX_SHIFT, $urandom_range(0, 5) == 0 ? $urandom_range(4096, 8191)
                                                           : $urandom_range(0, 4096));
    endtask

    task automatic test_directed;
        write_reg(REG_START_FREQ, 204800);
        write_reg(REG_CHANNEL_STEP, 20'(-100));
        write_reg(REG_DELAY_SCALE, 40'd500000);
        write_reg(REG_MAX_SHIFT, 13'd4096);
        send_sample(0, 0, 16'h8000, 1);
        send_sample(1023, 1023, 16'h7FFF, 1);
        send_sample(512, 300, 16'hFFFF, 1);
        send_sample(10, 5, 0, 1);
        drain();
        // huge scale: excess delay clamps to max_shift, itself capped at 4096
        write_reg(REG_DELAY_SCALE, 40'hFF_FFFF_FFFF);
        write_reg(REG_MAX_SHIFT, 13'd8191);
        send_sample(1023, 0, 16'h1234, 1);
        send_sample(1, 1023, 16'h5555, 1);
        send_sample(0, 512, 16'hAAAA, 1);
        drain();
        // positive step: negative delay, frequency above range
        write_reg(REG_CHANNEL_STEP, 20'h7FFFF);
        write_reg(REG_MAX_SHIFT, 13'd100);
        send_sample(1, 7, 16'h0001, 1);
        send_sample(1023, 9, 16'h8001, 1);
        drain();
        // start of zero, step most negative: frequency below range
        write_reg(REG_START_FREQ, 0);
        write_reg(REG_CHANNEL_STEP, 20'h80000);
        write_reg(REG_DELAY_SCALE, 40'd1);
        write_reg(REG_MAX_SHIFT, 0);
        send_sample(0, 0, 16'h0F0F, 1);
        send_sample(1023, 1023, 16'hF0F0, 1);
        drain();
        write_reg(REG_START_FREQ, 20'hFFFFF);
        send_sample(2, 3, 16'h3C3C, 1);
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 30; ph++)
        begin
            random_setting();
            for (int n = 0; n < 50; n++)
                send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                            16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 3) != 0);
            drain();
        end
    endtask

    task automatic test_backpressure;
        hold_off = 1'b1;
        random_setting();
        for (int n = 0; n < 100; n++)
            send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                        16'($urandom_range(0, 16'hFFFF)), 0);
        // sender pauses until everything is back
        drain();
    endtask

    // result sink with random stalls and one long hold-off
    initial
    begin
        int wait_n;
        forever
        begin
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        remap_t got, exp_r;
        if (m_tvalid && m_tready)
        begin
            got = '{m_tdata[9:0], m_tdata[22:10], m_tdata[38:23], m_tuser};
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected item: %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (got.chan !== exp_r.chan)
                    begin $display("%0t chan exp %0d got %0d", $time, exp_r.chan, got.chan);
                    errors++; end
                if (got.col !== exp_r.col)
                    begin $display("%0t col exp %0d got %0d", $time, exp_r.col, got.col);
                    errors++; end
                if (got.samp !== exp_r.samp)
                    begin $display("%0t samp exp %h got %h", $time, exp_r.samp, got.samp);
                    errors++; end
                if (got.clamped !== exp_r.clamped)
                    begin $display("%0t clamp exp %b got %b", $time, exp_r.clamped,
                                   got.clamped); errors++; end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        f0_reg = START_FREQ_RST;
        step_reg = CHANNEL_STEP_RST;
        scale_reg = DELAY_SCALE_RST;
        shift_reg = MAX_SHIFT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // default registers first
        send_sample(100, 20, 16'h4321, 1);
        drain();
        test_directed();
        test_backpressure();
        test_random();
        if (expected_q.size() != 0)
        begin
            $display("%0t %0d results missing", $time, expected_q.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== dispersion_delay_remap_unit.f =====
sv/ddr_pkg.sv
sv/ddr_front.sv
sv/ddr_recip.sv
sv/ddr_delay.sv
sv/dispersion_delay_remap_unit.sv
verif/tb_top.sv
